// ===== rtl/spc_pkg.sv =====
// Shared types and constants for the shortest-path counter.
`default_nettype none
package spc_pkg;
    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_QUERY = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_RANGE = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic take;        // latch the input transaction
        logic store_edge;  // write edge store, bump total
        logic clear_edges;
        logic clr_vtx;     // write zero at clear pointer
        logic init_src;    // seed source vertex, queue
        logic pop;         // read next queue entry
        logic cur_load;    // capture popped vertex info
        logic edge_rd;     // issue edge read
        logic nb_rd;       // read neighbour state
        logic nb_upd;      // apply update
        logic finish_rd;   // read target state
        logic emit;        // drive result
        logic [1:0] emit_err;
        logic emit_query;
    } spc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic range_bad;
        logic store_full;
        logic clr_done;
        logic queue_empty;
        logic edges_done;
        logic is_query;
        logic [1:0] action;
        logic side_b;      // second endpoint of current edge pending
        logic hit_a;
        logic hit_b;
    } spc_sts_t;
endpackage
`default_nettype wire

// ===== rtl/shortest_path_count_bfs.sv =====
// Top level of the breadth-first shortest-path counter.
// channel   | ports                                        | handshake
// command   | action, vertex_a, vertex_b                   | start & !busy
// result    | path_count, count_saturated, error_code      | done, one cycle
// config    | vtx_limit_we, vtx_limit_wdata                | vtx_limit_we
// Edge add and clear: the decode state emits the result, registered onto done; a write-back
// state leads to idle. Query: decode, a clear of every vertex table entry whose last step
// seeds the source, then per dequeued vertex a walk of the edge store, with a neighbour
// read and update per matching side (both for a self-loop); the target is then read and
// emitted. Reset empties the graph and sets the vertex limit to 256. The receiver
// cannot stall: done marks each result for one cycle.
`default_nettype none
module shortest_path_count_bfs
    import spc_pkg::*;
#(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_EDGES    = 1024,
    parameter int COUNT_WIDTH  = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  action,
    input  wire logic [7:0]  vertex_a,
    input  wire logic [7:0]  vertex_b,
    input  wire logic        vtx_limit_we,
    input  wire logic [8:0]  vtx_limit_wdata,
    output logic             done,
    output logic [31:0]      path_count,
    output logic             count_saturated,
    output logic [1:0]       error_code
);
    logic [8:0] vc_reg;
    spc_cmd_t cmd;
    spc_sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= 9'd256;
        else if (vtx_limit_we)
            vc_reg <= vtx_limit_wdata;
    end

    spc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .sts(sts), .cmd(cmd)
    );

    spc_datapath #(
        .MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES), .COUNT_WIDTH(COUNT_WIDTH)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .action(action), .vertex_a(vertex_a),
        .vertex_b(vertex_b), .vtx_limit(vc_reg), .cmd(cmd), .sts(sts),
        .path_count(path_count), .count_saturated(count_saturated),
        .error_code(error_code)
    );

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cmd.take) else $error("take while busy");
    a_done_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> done) else $error("result strobe missing");
    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (error_code == ERR_OK || error_code == ERR_RANGE ||
                  error_code == ERR_FULL)) else $error("bad error code");
endmodule
`default_nettype wire

// ===== rtl/spc_datapath.sv =====
// Edge store, vertex tables, search queue and counting arithmetic.
`default_nettype none
module spc_datapath
    import spc_pkg::*;
#(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_EDGES    = 1024,
    parameter int COUNT_WIDTH  = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [1:0] action,
    input  wire logic [7:0] vertex_a,
    input  wire logic [7:0] vertex_b,
    input  wire logic [8:0] vtx_limit,
    input  wire spc_cmd_t   cmd,
    output spc_sts_t        sts,
    output logic [31:0]     path_count,
    output logic            count_saturated,
    output logic [1:0]      error_code
);
    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int TW = $clog2(MAX_EDGES + 1);
    localparam int QW = $clog2(MAX_VERTICES + 1);
    localparam int CW = COUNT_WIDTH;
    localparam int DW = VW + 1;
    localparam logic [CW-1:0] CMAX = '1;

    logic [7:0] edge_mem [MAX_EDGES];
    logic [7:0] edgb_mem [MAX_EDGES];
    logic [DW-1:0] depth_mem [MAX_VERTICES];
    logic [CW-1:0] paths_mem [MAX_VERTICES];
    logic [VW-1:0] queue_mem [MAX_VERTICES];

    logic [1:0] act_reg;
    logic [7:0] a_reg, b_reg;
    logic [8:0] used_reg;
    logic [TW-1:0] total_reg;
    logic [VW:0] clr_ptr_reg;
    logic [QW-1:0] head_reg, tail_reg;
    logic [TW-1:0] eptr_reg;
    logic [VW-1:0] cur_reg;
    logic [DW-1:0] cur_depth_reg;
    logic [CW-1:0] cur_paths_reg;
    logic [7:0] ex_reg, ey_reg;
    logic [VW-1:0] q_rd_reg;
    logic [DW-1:0] d_rd_reg;
    logic [CW-1:0] p_rd_reg;
    logic [VW-1:0] nb_reg;
    logic sat_reg;
    logic side_reg;

    // a limit value above the table size clips to the table size
    wire [8:0] used = (MAX_VERTICES < 512 && int'(vtx_limit) > MAX_VERTICES) ?
                      9'(MAX_VERTICES) : vtx_limit;
    wire e_ok = ({1'b0, ex_reg} < {1'b0, used_reg}) && ({1'b0, ey_reg} < {1'b0, used_reg});
    wire [VW-1:0] ex_v = VW'(ex_reg);
    wire [VW-1:0] ey_v = VW'(ey_reg);
    wire [CW:0] sum = {1'b0, p_rd_reg} + {1'b0, cur_paths_reg};
    wire [CW-1:0] sum_sat = sum[CW] ? CMAX : sum[CW-1:0];

    assign sts.range_bad  = ({1'b0, a_reg} >= {1'b0, used_reg}) ||
                            ({1'b0, b_reg} >= {1'b0, used_reg});
    assign sts.store_full = (total_reg == TW'(MAX_EDGES));
    assign sts.clr_done   = (clr_ptr_reg == (VW+1)'(MAX_VERTICES));
    assign sts.queue_empty = (head_reg == tail_reg);
    assign sts.edges_done = (eptr_reg == total_reg);
    assign sts.is_query   = (act_reg == ACT_QUERY);
    assign sts.action     = act_reg;
    assign sts.side_b     = side_reg;
    assign sts.hit_a      = e_ok && (ex_v == cur_reg);
    assign sts.hit_b      = e_ok && (ey_v == cur_reg);

    // Memories: synchronous ports.
    always_ff @(posedge clk)
    begin
        if (cmd.store_edge)
        begin
            edge_mem[EW'(total_reg)] <= a_reg;
            edgb_mem[EW'(total_reg)] <= b_reg;
        end
        if (cmd.edge_rd)
        begin
            ex_reg <= edge_mem[EW'(eptr_reg)];
            ey_reg <= edgb_mem[EW'(eptr_reg)];
        end
        if (cmd.pop)
            q_rd_reg <= queue_mem[VW'(head_reg)];
        if (cmd.init_src)
            queue_mem[0] <= VW'(a_reg);
        else if (cmd.nb_upd && p_rd_reg == '0 && tail_reg < QW'(MAX_VERTICES))
            queue_mem[VW'(tail_reg)] <= nb_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_vtx)
        begin
            depth_mem[VW'(clr_ptr_reg)] <= '0;
            paths_mem[VW'(clr_ptr_reg)] <= '0;
        end
        else if (cmd.init_src)
        begin
            paths_mem[VW'(a_reg)] <= CW'(1);
        end
        else if (cmd.nb_upd)
        begin
            if (p_rd_reg == '0)
            begin
                depth_mem[nb_reg] <= cur_depth_reg + DW'(1);
                paths_mem[nb_reg] <= cur_paths_reg;
            end
            else if (d_rd_reg == cur_depth_reg + DW'(1))
                paths_mem[nb_reg] <= sum_sat;
        end
        if (cmd.cur_load || cmd.nb_rd || cmd.finish_rd)
        begin
            d_rd_reg <= depth_mem[cmd.cur_load ? q_rd_reg :
                                  cmd.finish_rd ? VW'(b_reg) : nb_reg];
            p_rd_reg <= paths_mem[cmd.cur_load ? q_rd_reg :
                                  cmd.finish_rd ? VW'(b_reg) : nb_reg];
        end
    end

    // nb_reg chosen when neighbour read is launched; cur_reg is registered on cur_load
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            act_reg  <= action;
            a_reg    <= vertex_a;
            b_reg    <= vertex_b;
            used_reg <= used;
        end
        if (cmd.cur_load)
            cur_reg <= q_rd_reg;
        if (cmd.edge_rd)
            nb_reg <= nb_reg;
        else if (cmd.nb_rd)
            nb_reg <= nb_reg;
        else if (sts.hit_a && !side_reg)
            nb_reg <= ey_v;
        else
            nb_reg <= ex_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            clr_ptr_reg   <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            eptr_reg      <= '0;
            sat_reg       <= 1'b0;
            side_reg      <= 1'b0;
            cur_depth_reg <= '0;
            cur_paths_reg <= '0;
        end
        else
        begin
            if (cmd.clear_edges)
                total_reg <= '0;
            else if (cmd.store_edge)
                total_reg <= total_reg + TW'(1);
            if (cmd.take)
                clr_ptr_reg <= '0;
            else if (cmd.clr_vtx)
                clr_ptr_reg <= clr_ptr_reg + (VW+1)'(1);
            if (cmd.init_src)
            begin
                head_reg <= '0;
                tail_reg <= QW'(1);
                sat_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.pop)
                    head_reg <= head_reg + QW'(1);
                if (cmd.nb_upd)
                begin
                    if (p_rd_reg == '0)
                    begin
                        if (tail_reg < QW'(MAX_VERTICES))
                            tail_reg <= tail_reg + QW'(1);
                    end
                    else if (d_rd_reg == cur_depth_reg + DW'(1) && sum_sat == CMAX)
                        sat_reg <= 1'b1;
                end
            end
            // current vertex values captured from the read registers on the first edge read after cur_load
            if (cmd.pop)
                eptr_reg <= '0;
            else if (cmd.edge_rd)
                eptr_reg <= eptr_reg + TW'(1);
            if (cmd.edge_rd)
                side_reg <= 1'b0;
            else if (cmd.nb_rd)
                side_reg <= ~side_reg;
            if (cmd.edge_rd && eptr_reg == '0)
            begin
                cur_depth_reg <= d_rd_reg;
                cur_paths_reg <= p_rd_reg;
            end
        end
    end

    // Result register.
    logic [31:0] pc;
    logic        fl;
    always_comb
    begin
        if (CW > 32)
        begin
            pc = (p_rd_reg > CW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : 32'(p_rd_reg);
            fl = sat_reg || (p_rd_reg > CW'(32'hFFFF_FFFF));
        end
        else
        begin
            pc = 32'(p_rd_reg);
            fl = sat_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            path_count      <= cmd.emit_query ? pc : 32'd0;
            count_saturated <= cmd.emit_query ? fl : 1'b0;
            error_code      <= cmd.emit_err;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/spc_ctrl.sv =====
// Sequencer for edge loads, clears and breadth-first queries.
`default_nettype none
module spc_ctrl
    import spc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    output logic      done,
    input  wire spc_sts_t sts,
    output spc_cmd_t  cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_CLR   = 4'd2;
    localparam logic [3:0] S_POP   = 4'd3;
    localparam logic [3:0] S_CUR   = 4'd4;
    localparam logic [3:0] S_CUR2  = 4'd5;
    localparam logic [3:0] S_EDGE  = 4'd6;
    localparam logic [3:0] S_CHK   = 4'd7;
    localparam logic [3:0] S_NBRD  = 4'd8;
    localparam logic [3:0] S_NBUPD = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;
    localparam logic [3:0] S_FIN2  = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;
    localparam logic [3:0] S_WB    = 4'd13;

    logic [3:0] state_reg, state_next;
    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.emit;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.take = start;
                if (start)
                    state_next = S_DEC;
            end
            S_DEC:
            begin
                priority if (sts.action == ACT_NONE)
                    state_next = S_IDLE;
                else if (sts.action == ACT_CLEAR)
                begin
                    cmd.clear_edges = 1'b1;
                    cmd.emit = 1'b1;
                    cmd.emit_err = ERR_OK;
                    state_next = S_WB;
                end
                else if (sts.range_bad)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_err = ERR_RANGE;
                    state_next = S_WB;
                end
                else if (!sts.is_query)
                begin
                    cmd.store_edge = !sts.store_full;
                    cmd.emit = 1'b1;
                    cmd.emit_err = sts.store_full ? ERR_FULL : ERR_OK;
                    state_next = S_WB;
                end
                else
                    state_next = S_CLR;
            end
            S_CLR:
            begin
                if (sts.clr_done)
                begin
                    cmd.init_src = 1'b1;
                    state_next = S_POP;
                end
                else
                    cmd.clr_vtx = 1'b1;
            end
            S_POP:
            begin
                if (sts.queue_empty)
                begin
                    cmd.finish_rd = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.pop = 1'b1;
                    state_next = S_CUR;
                end
            end
            S_CUR:
            begin
                cmd.cur_load = 1'b1;
                state_next = S_CUR2;
            end
            S_CUR2:
                state_next = S_EDGE;
            S_EDGE:
            begin
                if (sts.edges_done)
                    state_next = S_POP;
                else
                begin
                    cmd.edge_rd = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                // first the x==cur side, then y==cur
                if ((!sts.side_b && sts.hit_a) || (sts.side_b && sts.hit_b))
                    state_next = S_NBRD;
                else if (!sts.side_b && sts.hit_b)
                    state_next = S_NBRD;
                else
                    state_next = S_EDGE;
            end
            S_NBRD:
            begin
                cmd.nb_rd = 1'b1;
                state_next = S_NBUPD;
            end
            S_NBUPD:
            begin
                cmd.nb_upd = 1'b1;
                state_next = (sts.side_b && sts.hit_a && sts.hit_b) ? S_CHK : S_EDGE;
            end
            S_FIN:
                state_next = S_FIN2;
            S_FIN2:
            begin
                cmd.emit = 1'b1;
                cmd.emit_query = 1'b1;
                cmd.emit_err = ERR_OK;
                state_next = S_WB;
            end
            S_WB:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire
